### design/md5_pkg.sv
package md5_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } work_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [5:0]  LAST_ROUND = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used in a given round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] q;
        logic [3:0] g;
        q = r[3:0];
        unique case (r[5:4])
            2'd0:    g = q;
            2'd1:    g = 4'(q * 4'd5 + 4'd1);
            2'd2:    g = 4'(q * 4'd3 + 4'd5);
            default: g = 4'(q * 4'd7);
        endcase
        return g;
    endfunction

endpackage

### design/md5_round.sv
module md5_round (
    input  md5_pkg::work_t work,
    input  logic [5:0]     round,
    input  logic [31:0]    km,      // round constant plus message word
    output md5_pkg::work_t work_out
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  amt;
    logic [63:0] dbl;

    always_comb begin
        unique case (round[5:4])
            2'd0:    f = (work.b & work.c) | (~work.b & work.d);
            2'd1:    f = (work.d & work.b) | (~work.d & work.c);
            2'd2:    f = work.b ^ work.c ^ work.d;
            default: f = work.c ^ (work.b | ~work.d);
        endcase
    end

    assign sum = work.a + f + km;
    assign amt = md5_pkg::ROT_AMT[{round[5:4], round[1:0]}];
    assign dbl = {sum, sum} << amt;

    assign work_out.a = work.d;
    assign work_out.b = work.b + dbl[63:32];
    assign work_out.c = work.b;
    assign work_out.d = work.c;

endmodule

### design/md5_message_digest.sv
// MD5 digest of a byte stream, one byte per input item (s_tuser marks a byte
// as present, s_tlast ends the message). A byte that does not fill the
// block leaves the input ready for the next item; the byte that fills a
// 64-byte block holds the input through a compression (setup, 64 rounds
// through the single round unit, chaining add). The message-ending item
// costs a padding step plus one or two such compressions. It takes two, with
// an extra step to build the length-only block, when fewer than nine bytes
// of the block are free. A final byte that fills the block runs its own
// compression first. The digest then leaves as two items, bytes 0-7 then
// 8-15 with m_tlast on the second. No input is taken until both are delivered.
module md5_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_half
    output logic        m_tlast    // last_half
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_PREP, S_ROUND, S_ADD, S_OUT0, S_OUT1
    } state_t;

    localparam md5_pkg::work_t CHAIN_INIT = '{
        a: md5_pkg::INIT_A, b: md5_pkg::INIT_B, c: md5_pkg::INIT_C, d: md5_pkg::INIT_D
    };

    state_t          state_reg, state_next;
    md5_pkg::work_t  chain_reg, chain_next;
    md5_pkg::work_t  work_reg, work_next;
    md5_pkg::work_t  round_out;
    logic [63:0]     bit_count_reg, bit_count_next;
    logic [5:0]      round_reg, round_next;
    logic [31:0]     km_reg, km_next;
    logic            pad_pend_reg, pad_pend_next;
    logic            need_len_reg, need_len_next;
    logic            final_reg, final_next;
    logic [31:0]     blk_reg [16];
    logic [31:0]     blk_next [16];
    logic [5:0]      pos;
    logic [5:0]      round_inc;

    assign pos       = bit_count_reg[8:3];
    assign round_inc = round_reg + 6'd1;

    md5_round u_round (
        .work     (work_reg),
        .round    (round_reg),
        .km       (km_reg),
        .work_out (round_out)
    );

    always_comb begin
        logic [5:0] idx;
        idx            = '0;
        state_next     = state_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        bit_count_next = bit_count_reg;
        round_next     = round_reg;
        km_next        = km_reg;
        pad_pend_next  = pad_pend_reg;
        need_len_next  = need_len_reg;
        final_next     = final_reg;
        blk_next       = blk_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        blk_next[pos[5:2]][{pos[1:0], 3'b000} +: 8] = s_tdata;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    if (s_tuser && pos == md5_pkg::LAST_POS) begin
                        state_next    = S_PREP;
                        pad_pend_next = s_tlast;
                    end else if (s_tlast) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // 0x80 at the current position, zeros after it
                for (int w = 0; w < 16; w++) begin
                    for (int l = 0; l < 4; l++) begin
                        idx = 6'(w * 4 + l);
                        if (idx == pos) begin
                            blk_next[4'(w)][8*l +: 8] = md5_pkg::PAD_MARK;
                        end else if (idx > pos) begin
                            blk_next[4'(w)][8*l +: 8] = 8'h00;
                        end
                    end
                end
                if (pos < md5_pkg::LEN_POS) begin
                    blk_next[14] = bit_count_reg[31:0];
                    blk_next[15] = bit_count_reg[63:32];
                    final_next   = 1'b1;
                end else begin
                    need_len_next = 1'b1;
                end
                state_next = S_PREP;
            end
            S_LEN: begin
                for (int w = 0; w < 14; w++) begin
                    blk_next[4'(w)] = '0;
                end
                blk_next[14]  = bit_count_reg[31:0];
                blk_next[15]  = bit_count_reg[63:32];
                need_len_next = 1'b0;
                final_next    = 1'b1;
                state_next    = S_PREP;
            end
            S_PREP: begin
                work_next  = chain_reg;
                round_next = '0;
                km_next    = md5_pkg::ROUND_K[0] + blk_reg[md5_pkg::msg_index(6'd0)];
                state_next = S_ROUND;
            end
            S_ROUND: begin
                work_next  = round_out;
                round_next = round_inc;
                // next round's constant plus message word, registered ahead of its round
                km_next    = md5_pkg::ROUND_K[round_inc]
                             + blk_reg[md5_pkg::msg_index(round_inc)];
                if (round_reg == md5_pkg::LAST_ROUND) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                priority if (pad_pend_reg) begin
                    pad_pend_next = 1'b0;
                    state_next    = S_PAD;
                end else if (need_len_reg) begin
                    state_next = S_LEN;
                end else if (final_reg) begin
                    state_next = S_OUT0;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT0: begin
                if (m_tready) begin
                    state_next = S_OUT1;
                end
            end
            S_OUT1: begin
                if (m_tready) begin
                    chain_next     = CHAIN_INIT;
                    bit_count_next = '0;
                    final_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            chain_reg     <= CHAIN_INIT;
            work_reg      <= '0;
            bit_count_reg <= '0;
            round_reg     <= '0;
            pad_pend_reg  <= 1'b0;
            need_len_reg  <= 1'b0;
            final_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            bit_count_reg <= bit_count_next;
            round_reg     <= round_next;
            pad_pend_reg  <= pad_pend_next;
            need_len_reg  <= need_len_next;
            final_reg     <= final_next;
        end
    end

    always_ff @(posedge aclk) begin
        km_reg  <= km_next;
        blk_reg <= blk_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign m_tlast  = (state_reg == S_OUT1);
    assign m_tdata  = (state_reg == S_OUT1) ? {chain_reg.d, chain_reg.c}
                                            : {chain_reg.b, chain_reg.a};

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest pending");

    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_ROUND) |-> (round_reg == 6'd0))
        else $error("round counter not at zero outside rounds");

    a_first_half: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !m_tlast)
        else $error("digest began with final half");

    a_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=>
            (chain_reg.a == md5_pkg::INIT_A && bit_count_reg == 64'd0))
        else $error("state not reinitialized after digest");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN_WAIT  = 200;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEM_TARGET = 800;

    typedef struct {
        logic [63:0] half;
        logic        tail;
    } digest_half_t;

    class md5_scoreboard;
        bit [31:0] sine_k [64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        int unsigned shift_amt [16] = '{
            7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
        };

        bit [31:0]    chain [4];
        bit [31:0]    msg_words [16];
        bit [63:0]    msg_bits;
        digest_half_t digest_q [$];
        int unsigned  errors;
        int unsigned  items;
        int unsigned  bytes_taken;
        int unsigned  messages;
        int unsigned  halves_checked;

        function new();
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            foreach (msg_words[i]) msg_words[i] = '0;
            msg_bits = '0;
        endfunction

        function void put_byte(int unsigned pos, bit [7:0] b);
            msg_words[4'(pos / 4)][(pos % 4) * 8 +: 8] = b;
        endfunction

        function void compress();
            bit [31:0] a, b, c, d, f, t;
            int unsigned r, g, s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (r = 0; r < 64; r++) begin
                case (r / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1: begin
                        f = (d & b) | (~d & c);
                        g = (5 * r + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                s = shift_amt[4'((r / 16) * 4 + r % 4)];
                t = a + f + sine_k[6'(r)] + msg_words[4'(g)];
                t = (t << s) | (t >> (32 - s));
                a = d;
                d = c;
                c = b;
                b = b + t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        // called for every accepted input item
        function void note_input(bit [7:0] b, bit present, bit tail);
            int unsigned pos, i;
            if (present || tail) begin
                items++;
            end
            if (present) begin
                pos = 32'(msg_bits[8:3]);
                put_byte(pos, b);
                msg_bits += 64'd8;
                bytes_taken++;
                if (pos == 63) begin
                    compress();
                end
            end
            if (tail) begin
                pos = 32'(msg_bits[8:3]);
                put_byte(pos, 8'h80);
                for (i = pos + 1; i < 64; i++) begin
                    put_byte(i, 8'h00);
                end
                // no room for the length field: spill into an extra block
                if (pos >= 56) begin
                    compress();
                    foreach (msg_words[j]) msg_words[j] = '0;
                end
                msg_words[14] = msg_bits[31:0];
                msg_words[15] = msg_bits[63:32];
                compress();
                digest_q.push_back('{half: {chain[1], chain[0]}, tail: 1'b0});
                digest_q.push_back('{half: {chain[3], chain[2]}, tail: 1'b1});
                messages++;
                restart();
            end
        endfunction

        task report(string what);
            $display("tb: mismatch on digest half %0d: %s", halves_checked, what);
            errors++;
        endtask

        task check_result(logic [63:0] half, logic tail);
            digest_half_t want;
            if (digest_q.size() == 0) begin
                report($sformatf("unexpected item %h tlast %b", half, tail));
            end else begin
                want = digest_q.pop_front();
                if (half !== want.half) begin
                    report($sformatf("data %h, want %h", half, want.half));
                end
                if (tail !== want.tail) begin
                    report($sformatf("tlast %b, want %b", tail, want.tail));
                end
            end
            halves_checked++;
        endtask

        function int unsigned pending();
            return digest_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    md5_scoreboard sb;
    bit          quiet = 1'b0;    // no idling on either side
    bit          choppy = 1'b0;   // sender may idle between items
    bit          calm = 1'b0;     // receiver stretch without stalls
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    md5_message_digest dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // digest receiver: checks items and decides tready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
        if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if ($urandom_range(0, 99) == 0) begin
            calm = !calm;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input bit [7:0] b, input bit present, input bit tail);
        if (!quiet && choppy && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= tail;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, present, tail);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_digests();
        go_idle();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // random bytes; ends on a byte item or on a separate byte-less item
    task automatic send_message(input int unsigned len, input bit end_on_byte);
        int unsigned i;
        choppy = $urandom_range(0, 2) != 0;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && i == len - 1);
        end
        if (!end_on_byte || len == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        int unsigned len;
        int unsigned near_edge [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty items, empty message, single extreme bytes, "abc", short messages mixed with empty items
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        wait_digests();

        // receiver holds off while short messages pile up at the input
        hold_requests++;
        repeat (4) send_message($urandom_range(1, 3), 1'b1);
        wait_digests();

        while (sb.items < ITEM_TARGET) begin
            quiet = sb.items > ITEM_TARGET - 120;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
                6, 7:             len = near_edge[4'($urandom_range(0, 9))];
                default:          len = $urandom_range(0, 130);
            endcase
            send_message(len, $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                wait_digests();
            end
        end

        wait_digests();
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("tb: %0d items carrying %0d bytes, %0d messages, %0d digest halves checked",
                 sb.items, sb.bytes_taken, sb.messages, sb.halves_checked);
        $display("tb: empty items and messages, padding edge lengths, long output hold");
        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
